[sv/dsjs_pkg.sv]
// Shared constants, types and state codes for the deadline slot job scheduler.
package dsjs_pkg;

    localparam int SLOTS     = 1024;
    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int VAL_W     = 10;
    localparam int DL_W      = 14;
    localparam int TOT_W     = 21;
    localparam int OUT_TOT_W = 20;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [VAL_W-1:0]  val_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        val_t  data;
    } slot_wr_t;

    typedef struct packed {
        logic [OUT_TOT_W-1:0] total_value;
        val_t                 dropped_value;
        logic                 rejected;
    } result_t;

endpackage

[sv/dsjs_if.sv]
// Valid/ready channel interfaces for job items and result items.
interface dsjs_job_if;
    logic                        valid;
    logic                        ready;
    logic                        start_over;
    logic [dsjs_pkg::VAL_W-1:0]  job_value;
    logic [dsjs_pkg::DL_W-1:0]   job_deadline;

    modport source (output valid, start_over, job_value, job_deadline, input ready);
    modport sink   (input valid, start_over, job_value, job_deadline, output ready);
endinterface

interface dsjs_res_if;
    logic                           valid;
    logic                           ready;
    logic [dsjs_pkg::OUT_TOT_W-1:0] total_value;
    logic [dsjs_pkg::VAL_W-1:0]     dropped_value;
    logic                           rejected;

    modport source (output valid, total_value, dropped_value, rejected, input ready);
    modport sink   (input valid, total_value, dropped_value, rejected, output ready);
endinterface

[sv/dsjs_slot_ram.sv]
// Slot table memory: one write port, one read port with registered read data.
module dsjs_slot_ram (
    input  logic               clk,
    input  dsjs_pkg::slot_wr_t wr,
    input  dsjs_pkg::addr_t    rd_addr,
    output dsjs_pkg::val_t     rd_data
);

    dsjs_pkg::val_t mem [dsjs_pkg::SLOTS];
    dsjs_pkg::val_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/dsjs_ctrl.sv]
// Sequencer: clearing sweep, downward slot walk with read-modify-write, running total.
module dsjs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    dsjs_job_if.sink            jobs,
    output dsjs_pkg::slot_wr_t  mem_wr,
    output dsjs_pkg::addr_t     mem_rd_addr,
    input  dsjs_pkg::val_t      mem_rd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output dsjs_pkg::result_t   res
);

    dsjs_pkg::state_t             state_reg, state_next;
    dsjs_pkg::addr_t              addr_reg, addr_next;
    dsjs_pkg::val_t               carry_reg, carry_next;
    dsjs_pkg::val_t               value_reg, value_next;
    logic [dsjs_pkg::DL_W-1:0]    deadline_reg, deadline_next;
    logic                         job_pend_reg, job_pend_next;
    logic [dsjs_pkg::TOT_W-1:0]   total_reg, total_next;

    logic                         accept;
    logic                         reject;
    logic                         swap;
    dsjs_pkg::val_t               carry_after;
    dsjs_pkg::addr_t              start_addr;
    logic [dsjs_pkg::TOT_W-1:0]   total_upd;

    assign accept = jobs.valid && jobs.ready;
    assign reject = (value_reg == '0) || (deadline_reg == '0);

    // Clamp a deadline beyond the table to the last slot.
    assign start_addr = (deadline_reg > dsjs_pkg::DL_W'(dsjs_pkg::SLOTS))
                        ? dsjs_pkg::ADDR_W'(dsjs_pkg::SLOTS - 1)
                        : dsjs_pkg::ADDR_W'(deadline_reg - dsjs_pkg::DL_W'(1));

    // Empty slots read as zero, so they always take the carried value.
    assign swap        = mem_rd_data < carry_reg;
    assign carry_after = swap ? mem_rd_data : carry_reg;

    assign total_upd = reject ? total_reg
                     : dsjs_pkg::TOT_W'(total_reg + dsjs_pkg::TOT_W'(value_reg)
                                        - dsjs_pkg::TOT_W'(carry_reg));

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        carry_next    = carry_reg;
        value_next    = value_reg;
        deadline_next = deadline_reg;
        job_pend_next = job_pend_reg;
        total_next    = total_reg;
        unique case (state_reg)
            dsjs_pkg::ST_CLEAR:
            begin
                addr_next = addr_reg + dsjs_pkg::ADDR_W'(1);
                if (addr_reg == dsjs_pkg::ADDR_W'(dsjs_pkg::SLOTS - 1))
                begin
                    state_next    = job_pend_reg ? dsjs_pkg::ST_START : dsjs_pkg::ST_IDLE;
                    job_pend_next = 1'b0;
                end
            end
            dsjs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    value_next    = jobs.job_value;
                    deadline_next = jobs.job_deadline;
                    if (jobs.start_over)
                    begin
                        state_next    = dsjs_pkg::ST_CLEAR;
                        addr_next     = '0;
                        job_pend_next = 1'b1;
                        total_next    = '0;
                    end
                    else
                    begin
                        state_next = dsjs_pkg::ST_START;
                    end
                end
            end
            dsjs_pkg::ST_START:
            begin
                if (reject)
                begin
                    carry_next = '0;
                    state_next = dsjs_pkg::ST_DONE;
                end
                else
                begin
                    carry_next = value_reg;
                    addr_next  = start_addr;
                    state_next = dsjs_pkg::ST_READ;
                end
            end
            dsjs_pkg::ST_READ:
            begin
                state_next = dsjs_pkg::ST_WALK;
            end
            dsjs_pkg::ST_WALK:
            begin
                carry_next = carry_after;
                if ((carry_after == '0) || (addr_reg == '0))
                begin
                    state_next = dsjs_pkg::ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg - dsjs_pkg::ADDR_W'(1);
                end
            end
            dsjs_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    total_next = total_upd;
                    state_next = dsjs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dsjs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        jobs.ready   = 1'b0;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = addr_reg;
        mem_wr.data  = carry_reg;
        mem_rd_addr  = addr_reg;
        res_valid    = 1'b0;
        unique case (state_reg)
            dsjs_pkg::ST_CLEAR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.data = '0;
            end
            dsjs_pkg::ST_IDLE:
            begin
                jobs.ready = 1'b1;
            end
            dsjs_pkg::ST_WALK:
            begin
                mem_wr.en   = swap;
                // Fetch the next slot down while this one is written back.
                mem_rd_addr = addr_reg - dsjs_pkg::ADDR_W'(1);
            end
            dsjs_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                mem_wr.en = 1'b0;
            end
        endcase
    end

    assign res.total_value   = total_upd[dsjs_pkg::OUT_TOT_W-1:0];
    assign res.dropped_value = carry_reg;
    assign res.rejected      = reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dsjs_pkg::ST_CLEAR;
            addr_reg     <= '0;
            job_pend_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            job_pend_reg <= job_pend_next;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg    <= carry_next;
        value_reg    <= value_next;
        deadline_reg <= deadline_next;
    end

`ifndef SYNTHESIS
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !res_valid)
        else $error("result offered the cycle after an item was taken");

    a_read_carries_value: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dsjs_pkg::ST_READ |-> carry_reg != '0)
        else $error("slot walk started with nothing to place");

    a_walk_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dsjs_pkg::ST_WALK) && ($past(state_reg) == dsjs_pkg::ST_WALK)
        |-> addr_reg == $past(addr_reg) - dsjs_pkg::ADDR_W'(1))
        else $error("slot walk skipped or repeated a slot");

    a_dropped_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> carry_reg <= value_reg)
        else $error("dropped value exceeds the offered value");
`endif

endmodule

[sv/deadline_slot_job_scheduler.sv]
// Deadline slot job scheduler: job channel in, result channel out.
//
// jobs carries start_over, job_value and job_deadline; results carries
// total_value, dropped_value and rejected, one result item per job item.
// Each job is offered to its deadline slot (clamped to the last slot) and
// the smaller value is carried down the table, one slot read-modify-write
// per cycle through the single slot memory, until it lands in an empty slot
// or falls off the bottom.
// The walk covers from 1 slot up to the deadline slot number of slots, at most
// 1024; a rejected job skips the walk.
// A start_over job first sweeps all 1024 slots of the table clear.
// One job is processed at a time; jobs.ready is high only between jobs.
// After reset the block sweeps all 1024 slots to empty before jobs.ready rises.
// A result waits in an output register; while results.ready is low the
// next job may still be taken and worked, and it holds only at its own end.
module deadline_slot_job_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    dsjs_job_if.sink   jobs,
    dsjs_res_if.source results
);

    dsjs_pkg::slot_wr_t mem_wr;
    dsjs_pkg::addr_t    mem_rd_addr;
    dsjs_pkg::val_t     mem_rd_data;
    logic               res_valid;
    logic               res_ready;
    dsjs_pkg::result_t  res;

    logic               out_valid_reg;
    dsjs_pkg::result_t  out_data_reg;

    dsjs_slot_ram u_ram (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dsjs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .jobs        (jobs),
        .mem_wr      (mem_wr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.total_value   = out_data_reg.total_value;
    assign results.dropped_value = out_data_reg.dropped_value;
    assign results.rejected      = out_data_reg.rejected;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the deadline slot job scheduler.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit          start_over;
        int unsigned value;
        int unsigned deadline;
        bit          typed;
        int unsigned total;
        int unsigned dropped;
        bit          rejected;
    } job_row_t;

    localparam int N_DIRECTED = 21;
    localparam int N_RANDOM   = 560;

    logic clk = 1'b0;
    logic rst_n;

    dsjs_job_if jobs_if ();
    dsjs_res_if res_if ();

    deadline_slot_job_scheduler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .jobs    (jobs_if),
        .results (res_if)
    );

    always #5 clk = ~clk;

    // Shadow of the slot table and running total
    dsjs_pkg::val_t             sched_table [dsjs_pkg::SLOTS];
    logic [dsjs_pkg::TOT_W-1:0] sched_total;
    dsjs_pkg::result_t          expected_results [$];
    job_row_t                   directed_jobs [N_DIRECTED];

    bit calm;
    int mismatches;
    int jobs_sent;
    int results_seen;
    int drops_seen;
    int rejects_seen;
    int clears_sent;

    function automatic dsjs_pkg::result_t schedule_job(input logic clear,
                                                       input dsjs_pkg::val_t value,
                                                       input logic [dsjs_pkg::DL_W-1:0] deadline);
        int unsigned       pos;
        dsjs_pkg::val_t    carry;
        dsjs_pkg::val_t    held;
        dsjs_pkg::result_t res;
        res = '0;
        if (clear)
        begin
            sched_table = '{default: '0};
            sched_total = '0;
        end
        if (value == 0 || deadline == 0)
        begin
            res.rejected = 1'b1;
        end
        else
        begin
            pos = (deadline > dsjs_pkg::SLOTS) ? dsjs_pkg::SLOTS - 1 : deadline - 1;
            if (sched_table[pos] == 0)
            begin
                sched_table[pos] = value;
                carry = '0;
            end
            else if (sched_table[pos] < value)
            begin
                carry = sched_table[pos];
                sched_table[pos] = value;
            end
            else
            begin
                carry = value;
            end
            // Carry the smaller value down until it finds an empty slot
            while (carry != 0 && pos > 0)
            begin
                pos--;
                if (sched_table[pos] == 0)
                begin
                    sched_table[pos] = carry;
                    carry = '0;
                end
                else if (sched_table[pos] < carry)
                begin
                    held = sched_table[pos];
                    sched_table[pos] = carry;
                    carry = held;
                end
            end
            res.dropped_value = carry;
            sched_total = sched_total + value - carry;
        end
        res.total_value = sched_total[dsjs_pkg::OUT_TOT_W-1:0];
        return res;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_job(input logic clear, input dsjs_pkg::val_t value,
                            input logic [dsjs_pkg::DL_W-1:0] deadline,
                            input bit typed, input dsjs_pkg::result_t typed_res);
        int                gap;
        dsjs_pkg::result_t predicted;
        gap = gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            jobs_if.valid = 1'b0;
        end
        @(negedge clk);
        jobs_if.valid        = 1'b1;
        jobs_if.start_over   = clear;
        jobs_if.job_value    = value;
        jobs_if.job_deadline = deadline;
        do
            @(posedge clk);
        while (!jobs_if.ready);
        predicted = schedule_job(clear, value, deadline);
        expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
        jobs_sent++;
        if (clear)
            clears_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        jobs_if.valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random back-pressure
    initial
    begin : result_sink
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                res_if.ready = 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        dsjs_pkg::result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (res_if.dropped_value != 0)
                drops_seen++;
            if (res_if.rejected)
                rejects_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: total %0d dropped %0d rejected %0b",
                         $time, res_if.total_value, res_if.dropped_value, res_if.rejected);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("total_value", 32'(want.total_value), 32'(res_if.total_value));
                check_field("dropped_value", 32'(want.dropped_value),
                            32'(res_if.dropped_value));
                check_field("rejected", 32'(want.rejected), 32'(res_if.rejected));
            end
        end
    end

    initial
    begin : watchdog
        #60_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : job_source
        int                            pick;
        logic                          clear;
        dsjs_pkg::val_t                value;
        logic [dsjs_pkg::DL_W-1:0]     deadline;
        dsjs_pkg::result_t             typed_res;

        jobs_if.valid        = 1'b0;
        jobs_if.start_over   = 1'b0;
        jobs_if.job_value    = '0;
        jobs_if.job_deadline = '0;
        rst_n       = 1'b0;
        calm        = 1'b0;
        sched_table = '{default: '0};
        sched_total = '0;

        directed_jobs = '{
            '{0,    0,     5, 1,    0,   0, 1},  // zero value
            '{0,    7,     0, 1,    0,   0, 1},  // zero deadline
            '{0, 1023, 16383, 1, 1023,   0, 0},  // clamp to last slot
            '{0, 1000,  1024, 0,    0,   0, 0},
            '{0,    1,     1, 0,    0,   0, 0},
            '{0,    1,     1, 0,    0,   0, 0},  // equal at bottom: drop
            '{0,    2,     1, 0,    0,   0, 0},
            '{1,    9,     2, 1,    9,   0, 0},  // clear, then insert
            '{0,    4,     2, 0,    0,   0, 0},
            '{0,    6,     2, 0,    0,   0, 0},  // swap on the way down
            '{0,    6,     2, 0,    0,   0, 0},  // equal occupant kept
            '{1,    0,     0, 1,    0,   0, 1},  // clear with a rejected job
            '{0, 1023,     1, 1, 1023,   0, 0},
            '{0,  512,     1, 1, 1023, 512, 0},
            '{0,    0, 16383, 1, 1023,   0, 1},
            '{1, 1023, 16383, 1, 1023,   0, 0},
            '{0,    1, 16383, 0,    0,   0, 0},
            '{0,  682,  5461, 0,    0,   0, 0},
            '{0,  341, 10922, 0,    0,   0, 0},
            '{0, 1000,     1, 0,    0,   0, 0},
            '{0, 1023,  1024, 0,    0,   0, 0}   // equal at deadline slot
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_jobs[i])
        begin
            typed_res.total_value   = dsjs_pkg::OUT_TOT_W'(directed_jobs[i].total);
            typed_res.dropped_value = dsjs_pkg::VAL_W'(directed_jobs[i].dropped);
            typed_res.rejected      = directed_jobs[i].rejected;
            send_job(directed_jobs[i].start_over, dsjs_pkg::VAL_W'(directed_jobs[i].value),
                     dsjs_pkg::DL_W'(directed_jobs[i].deadline), directed_jobs[i].typed,
                     typed_res);
        end

        typed_res = '0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Every fourth block of 40 items runs with no idling on either side
            calm = ((n / 40) % 4) == 3;
            if (n == 200 || $urandom_range(0, 99) == 0)
                drain_results();

            clear = $urandom_range(0, 99) < 2;

            pick = $urandom_range(0, 99);
            if (pick < 5)
                value = '0;
            else if (pick < 10)
                value = 10'd1023;
            else if (pick < 40)
                value = dsjs_pkg::VAL_W'($urandom_range(1, 8));
            else
                value = dsjs_pkg::VAL_W'($urandom_range(1, 1023));

            // Mostly low deadlines so the bottom of the table fills and drops
            pick = $urandom_range(0, 99);
            if (pick < 4)
                deadline = '0;
            else if (pick < 60)
                deadline = dsjs_pkg::DL_W'($urandom_range(1, 24));
            else if (pick < 72)
                deadline = dsjs_pkg::DL_W'($urandom_range(990, dsjs_pkg::SLOTS));
            else if (pick < 85)
                deadline = dsjs_pkg::DL_W'($urandom_range(1, dsjs_pkg::SLOTS));
            else
                deadline = dsjs_pkg::DL_W'($urandom_range(dsjs_pkg::SLOTS + 1, 16383));

            send_job(clear, value, deadline, 1'b0, typed_res);
        end
        calm = 1'b0;

        @(negedge clk);
        jobs_if.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d jobs (%0d with start_over), checked %0d results",
                 jobs_sent, clears_sent, results_seen);
        $display("Results with a dropped job: %0d, rejected jobs: %0d",
                 drops_seen, rejects_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
sv/dsjs_pkg.sv
sv/dsjs_if.sv
sv/dsjs_slot_ram.sv
sv/dsjs_ctrl.sv
sv/deadline_slot_job_scheduler.sv
tb/testbench.sv
